>>> hdl/rgbfx_pkg.sv
// Shared constants, types, micro-op format and sine table builder for the RGB LED effect core.
`timescale 1ns / 1ps
`default_nettype none

package rgbfx_pkg;

  localparam int unsigned SINE_ENTRIES = 256;
  localparam int unsigned SE_W         = $clog2(SINE_ENTRIES + 1);
  localparam int unsigned PIDX_W       = 30 + SE_W;
  localparam int unsigned DIV_W        = 17;
  localparam int unsigned ACC_W        = 24;

  localparam logic [19:0]     TURN_SCALE  = 20'd683565;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam logic [29:0]     RND_HALF    = 30'h2000_0000;
  localparam logic [12:0]     PHASE_LIMIT = 13'd6280;
  localparam logic [15:0]     SINE_BIAS   = 16'd32767;
  localparam logic [16:0]     DIV_HALF    = 17'd32767;
  localparam logic [16:0]     DIV_FULL    = 17'd65534;

  typedef logic [7:0]  level_t;
  typedef logic [3:0]  mode_t;
  typedef logic [0:0]  cfg_idx_t;
  typedef logic [12:0] phase_t;
  typedef logic [13:0] angle_t;
  typedef logic [14:0] sine_t;

  localparam cfg_idx_t CFG_DEBOUNCE = 1'b0;
  localparam cfg_idx_t CFG_INVERT   = 1'b1;

  localparam mode_t MODE_OFF     = 4'd0;
  localparam mode_t MODE_PURPLE  = 4'd1;
  localparam mode_t MODE_FLICKER = 4'd2;
  localparam mode_t MODE_OCEAN   = 4'd3;
  localparam mode_t MODE_RAINBOW = 4'd4;
  localparam mode_t MODE_BREATH  = 4'd5;
  localparam mode_t MODE_PLASMA  = 4'd6;
  localparam mode_t MODE_SUNSET  = 4'd7;
  localparam mode_t MODE_AURORA  = 4'd8;

  typedef enum logic [1:0] {UK_DONE, UK_ANGLE, UK_MAC, UK_DIV} uop_kind_e;
  typedef enum logic [2:0] {ANG_WAVE, ANG_WAVE_B, ANG_WAVE_C, ANG_SLOW, ANG_AUX} ang_e;
  typedef enum logic [2:0] {DVD_RA, DVD_RB, DVD_RED, DVD_BLUE, DVD_AUR} dvd_e;
  typedef enum logic [1:0] {DVS_75, DVS_3, DVS_10, DVS_VAR} dvs_e;
  typedef enum logic [2:0] {
    DST_NONE, DST_RED, DST_GREEN, DST_BLUE, DST_TMP, DST_AUX
  } dst_e;

  typedef struct packed {
    uop_kind_e   kind;
    ang_e        ang;
    logic        u_sel;
    logic [7:0]  k;
    logic        acc;
    logic        bias;
    logic        by_half;
    dvd_e        dvd;
    dvs_e        dvs;
    logic        use_rem;
    dst_e        dst;
    logic [9:0]  offset;
  } uop_t;

  typedef sine_t sine_rom_t [SINE_ENTRIES + 1];

  // quarter-wave table, Taylor series in Q30, evaluated at elaboration
  function automatic sine_rom_t gen_sine_rom();
    sine_rom_t       rom;
    longint unsigned x;
    longint unsigned term;
    longint unsigned v;
    longint          sum;
    for (int i = 0; i <= SINE_ENTRIES; i++) begin
      x    = (64'(i) * HALF_PI_Q30) / SINE_ENTRIES;
      term = x;
      sum  = longint'(x);
      for (int k = 1; k <= 7; k++) begin
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = term / 64'((2 * k) * (2 * k + 1));
        if (k[0]) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      v = ((64'(sum) * 64'd32767) + 64'd536870912) >> 30;
      if (v > 64'd32767) begin
        v = 64'd32767;
      end
      rom[i] = sine_t'(v);
    end
    return rom;
  endfunction

endpackage

`default_nettype wire

>>> hdl/rgb_led_effect_generator_core.sv
// RGB LED effect core: debounced mode stepping, phase accumulators and micro-coded effects.
//
// Usage: one input item per 20 ms tick (button level, ms time, two random words)
// on the in_valid_i / in_stall_o channel; one result item (three drive levels
// and the mode in effect) on out_valid_o / out_stall_i. Configuration writes
// (debounce time, drive inversion) go through cfg_we_i with cfg_index_i and
// cfg_wdata_i; the user must make them only while the block is idle, which the
// block itself does not enforce. Ops share one multiplier; a sine lookup goes
// through the turn scaling, index, rounding and table read steps, a scale step
// through multiply and fix, a division by a constant through reciprocal and
// back-multiply, and the flicker's variable modulus through a serial
// shift/subtract divider.
// One item is worked on at a time: in_stall_o is high from acceptance until the
// result is loaded into the output register. The next item is taken while a
// result still waits in that register.
// When the receiver stalls, the result holds and a finished next result waits
// in its last step until the register frees up.
// Reset: mode off, button released, press time and phases zero, debounce
// 250 ms, inversion on, no result pending.
`timescale 1ns / 1ps
`default_nettype none

module rgb_led_effect_generator_core (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire rgbfx_pkg::cfg_idx_t cfg_index_i,
  input  wire logic [15:0]         cfg_wdata_i,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic                button_level_i,
  input  wire logic [31:0]         now_ms_i,
  input  wire logic [15:0]         rand_a_i,
  input  wire logic [15:0]         rand_b_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output rgbfx_pkg::level_t        drive_red_o,
  output rgbfx_pkg::level_t        drive_green_o,
  output rgbfx_pkg::level_t        drive_blue_o,
  output rgbfx_pkg::mode_t         active_mode_o
);
  import rgbfx_pkg::*;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_PHASE = 4'd1;
  localparam logic [3:0] ST_DISP  = 4'd2;
  localparam logic [3:0] ST_TURN  = 4'd3;
  localparam logic [3:0] ST_INDEX = 4'd4;
  localparam logic [3:0] ST_ROUND = 4'd5;
  localparam logic [3:0] ST_ROM   = 4'd6;
  localparam logic [3:0] ST_MUL   = 4'd7;
  localparam logic [3:0] ST_FIX   = 4'd8;
  localparam logic [3:0] ST_DIV   = 4'd9;
  localparam logic [3:0] ST_OUT   = 4'd10;
  localparam logic [3:0] ST_RCP   = 4'd11;
  localparam logic [3:0] ST_BACK  = 4'd12;

  localparam sine_rom_t SINE_ROM = gen_sine_rom();

  localparam logic [7:0] FLICKER_MOD = 8'd75;
  localparam logic [7:0] GREEN_FLOOR = 8'd40;

  // x / 75 = (x * 111849) >> 23 below 2^16, x / 3 = (x * 171) >> 9 below 2^8,
  // x / 10 = (x * 52429) >> 19 below 81920
  localparam logic [19:0] RCP_75 = 20'd111849;
  localparam logic [19:0] RCP_3  = 20'd171;
  localparam logic [19:0] RCP_10 = 20'd52429;

  function automatic phase_t advance(input phase_t phase, input phase_t step);
    phase_t p;
    p = phase + step;
    return (p > PHASE_LIMIT) ? '0 : p;
  endfunction

  function automatic uop_t ucode(input mode_t mode, input logic [2:0] step);
    uop_t u;
    u      = '0;
    u.kind = UK_DONE;
    case (mode)
      MODE_FLICKER: begin
        case (step)
          3'd0: begin
            u.kind = UK_DIV; u.dvd = DVD_RA; u.dvs = DVS_75; u.use_rem = 1'b1;
            u.dst = DST_RED; u.offset = 10'd180;
          end
          3'd1: begin
            u.kind = UK_DIV; u.dvd = DVD_RED; u.dvs = DVS_3; u.dst = DST_TMP;
          end
          3'd2: begin
            u.kind = UK_DIV; u.dvd = DVD_RB; u.dvs = DVS_VAR; u.use_rem = 1'b1;
            u.dst = DST_GREEN; u.offset = 10'd40;
          end
          default: u.kind = UK_DONE;
        endcase
      end
      MODE_RAINBOW: begin
        case (step)
          3'd0: begin u.kind = UK_ANGLE; u.ang = ANG_WAVE; end
          3'd1: begin
            u.kind = UK_MAC; u.k = 8'd127; u.bias = 1'b1; u.by_half = 1'b1; u.dst = DST_RED;
          end
          3'd2: begin u.kind = UK_ANGLE; u.ang = ANG_WAVE_B; end
          3'd3: begin
            u.kind = UK_MAC; u.k = 8'd127; u.bias = 1'b1; u.by_half = 1'b1;
            u.dst = DST_GREEN;
          end
          3'd4: begin u.kind = UK_ANGLE; u.ang = ANG_WAVE_C; end
          3'd5: begin
            u.kind = UK_MAC; u.k = 8'd127; u.bias = 1'b1; u.by_half = 1'b1; u.dst = DST_BLUE;
          end
          default: u.kind = UK_DONE;
        endcase
      end
      MODE_BREATH: begin
        case (step)
          3'd0: begin u.kind = UK_ANGLE; u.ang = ANG_SLOW; end
          3'd1: begin u.kind = UK_MAC; u.k = 8'd255; u.dst = DST_BLUE; end
          3'd2: begin
            u.kind = UK_DIV; u.dvd = DVD_BLUE; u.dvs = DVS_3; u.dst = DST_RED;
          end
          default: u.kind = UK_DONE;
        endcase
      end
      MODE_PLASMA: begin
        case (step)
          3'd0: begin u.kind = UK_ANGLE; u.ang = ANG_SLOW; end
          3'd1: begin u.kind = UK_MAC; u.k = 8'd150; u.dst = DST_RED; end
          3'd2: begin u.kind = UK_MAC; u.k = 8'd255; u.dst = DST_BLUE; end
          default: u.kind = UK_DONE;
        endcase
      end
      MODE_SUNSET: begin
        case (step)
          3'd0: begin u.kind = UK_ANGLE; u.ang = ANG_SLOW; end
          3'd1: begin
            u.kind = UK_MAC; u.k = 8'd100; u.dst = DST_GREEN; u.offset = 10'd80;
          end
          3'd2: begin u.kind = UK_MAC; u.k = 8'd50; u.dst = DST_BLUE; end
          default: u.kind = UK_DONE;
        endcase
      end
      MODE_AURORA: begin
        case (step)
          3'd0: begin u.kind = UK_ANGLE; u.ang = ANG_WAVE; end
          3'd1: begin
            u.kind = UK_DIV; u.dvd = DVD_AUR; u.dvs = DVS_10; u.dst = DST_AUX;
            u.offset = 10'd1000;
          end
          3'd2: begin u.kind = UK_ANGLE; u.ang = ANG_AUX; u.u_sel = 1'b1; end
          3'd3: begin u.kind = UK_MAC; u.k = 8'd100; u.dst = DST_RED; end
          3'd4: begin u.kind = UK_MAC; u.k = 8'd255; u.u_sel = 1'b1; u.dst = DST_GREEN; end
          3'd5: begin u.kind = UK_MAC; u.k = 8'd200; u.dst = DST_NONE; end
          3'd6: begin
            u.kind = UK_MAC; u.k = 8'd55; u.u_sel = 1'b1; u.acc = 1'b1; u.dst = DST_BLUE;
          end
          default: u.kind = UK_DONE;
        endcase
      end
      default: u.kind = UK_DONE;
    endcase
    return u;
  endfunction

  logic [3:0]  st_q, st_d;
  logic [2:0]  step_q;
  mode_t       mode_q;
  logic        prev_q;
  logic [31:0] press_q;
  phase_t      slow_q, wave_q;
  logic [15:0] debounce_q;
  logic        invert_q;
  logic        out_valid_q;
  logic [4:0]  cnt_q;

  logic [15:0]       ra_q, rb_q;
  level_t            red_q, green_q, blue_q, tmp_q;
  angle_t            aux_q;
  logic [31:0]       t_q;
  logic [PIDX_W-1:0] pidx_q;
  logic [SE_W-1:0]   idx_q;
  logic [15:0]       u1_q, u2_q;
  logic [ACC_W-1:0]  acc_q;
  logic [DIV_W-1:0]  dq_q;
  logic [7:0]        dr_q, dd_q;
  level_t            drive_red_q, drive_green_q, drive_blue_q;
  mode_t             active_mode_q;

  uop_t uop;
  logic in_acc, out_free, press_ok;
  mode_t mode_next;

  assign uop       = ucode(mode_q, step_q);
  assign in_acc    = in_valid_i && (st_q == ST_IDLE);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign press_ok  = !button_level_i && prev_q &&
                     ((now_ms_i - press_q) > 32'(debounce_q));
  assign mode_next = (mode_q >= MODE_AURORA) ? MODE_OFF : mode_q + 4'd1;

  // angle source
  angle_t angle;
  always_comb begin
    case (uop.ang)
      ANG_WAVE:   angle = 14'(wave_q);
      ANG_WAVE_B: angle = 14'(wave_q) + 14'd2090;
      ANG_WAVE_C: angle = 14'(wave_q) + 14'd4180;
      ANG_SLOW:   angle = 14'(slow_q);
      ANG_AUX:    angle = aux_q;
      default:    angle = 14'(wave_q);
    endcase
  end

  // divider operands and reciprocal of the constant divisors
  logic [DIV_W-1:0] dvd_val;
  logic [7:0]       dvs_val;
  logic [19:0]      rcp_m;
  always_comb begin
    case (uop.dvd)
      DVD_RA:   dvd_val = DIV_W'(ra_q);
      DVD_RB:   dvd_val = DIV_W'(rb_q);
      DVD_RED:  dvd_val = DIV_W'(red_q);
      DVD_BLUE: dvd_val = DIV_W'(blue_q);
      DVD_AUR:  dvd_val = DIV_W'(wave_q) * DIV_W'(13);
      default:  dvd_val = '0;
    endcase
    case (uop.dvs)
      DVS_75: begin
        dvs_val = FLICKER_MOD;
        rcp_m   = RCP_75;
      end
      DVS_3: begin
        dvs_val = 8'd3;
        rcp_m   = RCP_3;
      end
      DVS_10: begin
        dvs_val = 8'd10;
        rcp_m   = RCP_10;
      end
      DVS_VAR: begin
        dvs_val = tmp_q - GREEN_FLOOR;
        rcp_m   = '0;
      end
      default: begin
        dvs_val = 8'd1;
        rcp_m   = '0;
      end
    endcase
  end

  // shared multiplier
  logic [29:0] mul_a;
  logic [19:0] mul_b;
  logic [49:0] prod;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (st_q)
      ST_TURN: begin
        mul_a = 30'(angle);
        mul_b = TURN_SCALE;
      end
      ST_INDEX: begin
        mul_a = t_q[29:0];
        mul_b = 20'(SINE_ENTRIES);
      end
      ST_MUL: begin
        mul_a = 30'(uop.u_sel ? u2_q : u1_q);
        mul_b = 20'(uop.k);
      end
      ST_RCP: begin
        mul_a = 30'(dvd_val);
        mul_b = rcp_m;
      end
      ST_BACK: begin
        mul_a = 30'(dq_q);
        mul_b = 20'(dvs_val);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign prod = 50'(mul_a) * 50'(mul_b);

  // table index: round, clip, mirror in odd quadrants
  logic [PIDX_W:0] rsum;
  logic [SE_W:0]   idx_raw, idx_clip, idx_mir;
  assign rsum     = {1'b0, pidx_q} + (PIDX_W + 1)'(RND_HALF);
  assign idx_raw  = rsum[PIDX_W:30];
  assign idx_clip = (idx_raw > (SE_W + 1)'(SINE_ENTRIES)) ? (SE_W + 1)'(SINE_ENTRIES) : idx_raw;
  assign idx_mir  = t_q[30] ? (SE_W + 1)'(SINE_ENTRIES) - idx_clip : idx_clip;

  sine_t       sine_v;
  logic [15:0] u_new;
  assign sine_v = SINE_ROM[idx_q];
  assign u_new  = t_q[31] ? SINE_BIAS - 16'(sine_v) : SINE_BIAS + 16'(sine_v);

  // multiply-accumulate and division by 65534 or 32767
  logic [ACC_W-1:0] acc_base, acc_d;
  assign acc_base = uop.acc ? acc_q : (uop.bias ? ACC_W'(SINE_BIAS) : '0);
  assign acc_d    = acc_base + prod[ACC_W-1:0];

  logic [8:0]  fq0, fq;
  logic [16:0] fr;
  logic        fcorr;
  always_comb begin
    if (uop.by_half) begin
      fq0   = acc_q[23:15];
      fr    = 17'(acc_q[14:0]) + 17'(fq0);
      fcorr = (fr >= DIV_HALF);
    end else begin
      fq0   = {1'b0, acc_q[23:16]};
      fr    = 17'(acc_q[15:0]) + 17'({fq0, 1'b0});
      fcorr = (fr >= DIV_FULL);
    end
    fq = fq0 + 9'(fcorr);
  end

  // serial divider step
  logic [8:0]       dsh, ddif;
  logic             dge;
  logic [DIV_W-1:0] dquo;
  logic [7:0]       drem;
  assign dsh  = {dr_q, dq_q[DIV_W-1]};
  assign dge  = (dsh >= {1'b0, dd_q});
  assign ddif = dsh - {1'b0, dd_q};
  assign dquo = {dq_q[DIV_W-2:0], dge};
  assign drem = dge ? ddif[7:0] : dsh[7:0];

  // constant divisors: quotient from the reciprocal product, remainder from the back-multiply
  logic [DIV_W-1:0] rcp_quo, rcp_rem;
  always_comb begin
    case (uop.dvs)
      DVS_75:  rcp_quo = prod[23 +: DIV_W];
      DVS_3:   rcp_quo = prod[9 +: DIV_W];
      DVS_10:  rcp_quo = prod[19 +: DIV_W];
      default: rcp_quo = '0;
    endcase
  end
  assign rcp_rem = dvd_val - prod[DIV_W-1:0];

  // result write-back
  logic   wr_en;
  angle_t wr_val;
  always_comb begin
    wr_en  = 1'b0;
    wr_val = '0;
    case (st_q)
      ST_FIX: begin
        wr_en  = 1'b1;
        wr_val = 14'(fq) + 14'(uop.offset);
      end
      ST_DIV: begin
        wr_en  = (cnt_q == '0);
        wr_val = (uop.use_rem ? 14'(drem) : 14'(dquo)) + 14'(uop.offset);
      end
      ST_BACK: begin
        wr_en  = 1'b1;
        wr_val = (uop.use_rem ? 14'(rcp_rem[7:0]) : 14'(dq_q)) + 14'(uop.offset);
      end
      default: begin
        wr_en  = 1'b0;
        wr_val = '0;
      end
    endcase
  end

  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE:  if (in_valid_i) st_d = ST_PHASE;
      ST_PHASE: st_d = ST_DISP;
      ST_DISP: begin
        case (uop.kind)
          UK_ANGLE: st_d = ST_TURN;
          UK_MAC:   st_d = ST_MUL;
          UK_DIV:   st_d = (uop.dvs == DVS_VAR) ? ST_DIV : ST_RCP;
          default:  st_d = ST_OUT;
        endcase
      end
      ST_TURN:  st_d = ST_INDEX;
      ST_INDEX: st_d = ST_ROUND;
      ST_ROUND: st_d = ST_ROM;
      ST_ROM:   st_d = ST_DISP;
      ST_MUL:   st_d = ST_FIX;
      ST_FIX:   st_d = ST_DISP;
      ST_DIV:   if (cnt_q == '0) st_d = ST_DISP;
      ST_RCP:   st_d = ST_BACK;
      ST_BACK:  st_d = ST_DISP;
      ST_OUT:   if (out_free) st_d = ST_IDLE;
      default:  st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      step_q      <= '0;
      mode_q      <= MODE_OFF;
      prev_q      <= 1'b1;
      press_q     <= '0;
      slow_q      <= '0;
      wave_q      <= '0;
      debounce_q  <= 16'd250;
      invert_q    <= 1'b1;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      st_q <= st_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_DEBOUNCE: debounce_q <= cfg_wdata_i;
          CFG_INVERT:   invert_q   <= cfg_wdata_i[0];
          default:      ;
        endcase
      end
      if (in_acc) begin
        prev_q <= button_level_i;
        step_q <= '0;
        if (press_ok) begin
          mode_q  <= mode_next;
          press_q <= now_ms_i;
          slow_q  <= '0;
          wave_q  <= '0;
        end
      end
      if (st_q == ST_PHASE) begin
        case (mode_q)
          MODE_RAINBOW: wave_q <= advance(wave_q, 13'd10);
          MODE_AURORA:  wave_q <= advance(wave_q, 13'd15);
          MODE_BREATH:  slow_q <= advance(slow_q, 13'd20);
          MODE_PLASMA:  slow_q <= advance(slow_q, 13'd50);
          MODE_SUNSET:  slow_q <= advance(slow_q, 13'd5);
          default:      ;
        endcase
      end
      if ((st_q == ST_ROM) || (st_q == ST_FIX) || (st_q == ST_BACK) ||
          ((st_q == ST_DIV) && (cnt_q == '0))) begin
        step_q <= step_q + 3'd1;
      end
      if ((st_q == ST_DISP) && (uop.kind == UK_DIV)) begin
        cnt_q <= 5'(DIV_W - 1);
      end else if ((st_q == ST_DIV) && (cnt_q != '0)) begin
        cnt_q <= cnt_q - 5'd1;
      end
      if ((st_q == ST_OUT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ra_q <= rand_a_i;
      rb_q <= rand_b_i;
    end
    case (st_q)
      ST_PHASE: begin
        case (mode_q)
          MODE_PURPLE: begin red_q <= 8'd20;  green_q <= 8'd0;   blue_q <= 8'd80;  end
          MODE_OCEAN:  begin red_q <= 8'd0;   green_q <= 8'd100; blue_q <= 8'd255; end
          MODE_SUNSET: begin red_q <= 8'd255; green_q <= 8'd0;   blue_q <= 8'd0;   end
          default:     begin red_q <= 8'd0;   green_q <= 8'd0;   blue_q <= 8'd0;   end
        endcase
      end
      ST_DISP: begin
        if (uop.kind == UK_DIV) begin
          dq_q <= dvd_val;
          dr_q <= '0;
          dd_q <= dvs_val;
        end
      end
      ST_TURN:  t_q    <= prod[31:0];
      ST_INDEX: pidx_q <= prod[PIDX_W-1:0];
      ST_ROUND: idx_q  <= idx_mir[SE_W-1:0];
      ST_ROM: begin
        if (uop.u_sel) begin
          u2_q <= u_new;
        end else begin
          u1_q <= u_new;
        end
      end
      ST_MUL: acc_q <= acc_d;
      ST_DIV: begin
        dq_q <= dquo;
        dr_q <= drem;
      end
      ST_RCP: dq_q <= rcp_quo;
      ST_OUT: begin
        if (out_free) begin
          drive_red_q   <= invert_q ? ~red_q   : red_q;
          drive_green_q <= invert_q ? ~green_q : green_q;
          drive_blue_q  <= invert_q ? ~blue_q  : blue_q;
          active_mode_q <= mode_q;
        end
      end
      default: ;
    endcase
    if (wr_en) begin
      case (uop.dst)
        DST_RED:   red_q   <= wr_val[7:0];
        DST_GREEN: green_q <= wr_val[7:0];
        DST_BLUE:  blue_q  <= wr_val[7:0];
        DST_TMP:   tmp_q   <= wr_val[7:0];
        DST_AUX:   aux_q   <= wr_val;
        default:   ;
      endcase
    end
  end

  assign in_stall_o    = (st_q != ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign drive_red_o   = drive_red_q;
  assign drive_green_o = drive_green_q;
  assign drive_blue_o  = drive_blue_q;
  assign active_mode_o = active_mode_q;

endmodule

`default_nettype wire

>>> test/testbench.sv
// Testbench for the RGB LED effect core: directed and random ticks checked against listed values and a predictor.
`timescale 1ns / 1ps

module testbench;
  import rgbfx_pkg::*;

  localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;
  localparam longint unsigned MRAD_TO_TURN     = 64'd683565;
  localparam int unsigned     PHASE_WRAP_MRAD  = 6280;
  localparam int unsigned     LEVEL_FULL       = 65534;
  localparam int              HOLD_CYCLES      = 400;
  localparam int              DRAIN_CYCLES     = 64;
  localparam int              CYCLE_LIMIT      = 1000000;

  typedef struct packed {
    level_t red;
    level_t green;
    level_t blue;
    mode_t  mode;
  } drive_t;

  typedef struct {
    logic        btn;
    logic [31:0] now;
    logic [15:0] ra;
    logic [15:0] rb;
    bit          typed;
    drive_t      want;
  } tick_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  cfg_idx_t    cfg_index_i;
  logic [15:0] cfg_wdata_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        button_level_i;
  logic [31:0] now_ms_i;
  logic [15:0] rand_a_i;
  logic [15:0] rand_b_i;
  logic        out_valid_o;
  logic        out_stall_i;
  level_t      drive_red_o;
  level_t      drive_green_o;
  level_t      drive_blue_o;
  mode_t       active_mode_o;

  rgb_led_effect_generator_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .button_level_i (button_level_i),
    .now_ms_i       (now_ms_i),
    .rand_a_i       (rand_a_i),
    .rand_b_i       (rand_b_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .drive_red_o    (drive_red_o),
    .drive_green_o  (drive_green_o),
    .drive_blue_o   (drive_blue_o),
    .active_mode_o  (active_mode_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // predicted block state
  int          quarter_wave [0:SINE_ENTRIES];
  mode_t       fx_mode;
  logic        last_button;
  logic [31:0] press_ms;
  phase_t      slow_mrad;
  phase_t      wave_mrad;
  logic [15:0] debounce_limit;
  logic        invert_on;

  drive_t      pending_drives [$];
  tick_row_t   directed_rows [$];

  int          mismatch_count = 0;
  int          drives_checked = 0;
  int          ticks_sent = 0;
  int          settings_done = 0;
  int          cycle_count = 0;
  int          gap_burst = 0;
  logic [8:0]  modes_seen = '0;
  bit          hold_asked = 1'b0;
  bit          hold_served = 1'b0;

  // random button and clock generator
  logic [31:0] sim_ms = '0;
  logic        btn_level = 1'b1;
  int          btn_run = 0;
  bit          steady = 1'b0;

  function automatic int sine_q15(input int unsigned mrad);
    longint unsigned prod;
    logic [31:0]     turn;
    longint unsigned idx;
    int              v;
    prod = 64'(mrad) * MRAD_TO_TURN;
    turn = prod[31:0];
    idx  = (64'(turn[29:0]) * SINE_ENTRIES + 64'd536870912) >> 30;
    if (idx > SINE_ENTRIES) begin
      idx = SINE_ENTRIES;
    end
    if (turn[30]) begin
      idx = SINE_ENTRIES - idx;
    end
    v = quarter_wave[int'(idx)];
    return turn[31] ? -v : v;
  endfunction

  function automatic int unsigned unit_level(input int unsigned mrad);
    return int'(sine_q15(mrad) + 32767);
  endfunction

  function automatic int unsigned rainbow_level(input int unsigned mrad);
    int s;
    s = sine_q15(mrad);
    return (s * 127 + 128 * 32767) / 32767;
  endfunction

  function automatic phase_t phase_step(input phase_t p, input int unsigned step);
    phase_t s;
    s = p + step;
    return (s > PHASE_WRAP_MRAD) ? '0 : s;
  endfunction

  function automatic drive_t led_drive(input logic btn, input logic [31:0] now,
                                       input logic [15:0] ra, input logic [15:0] rb);
    drive_t      d;
    int unsigned r;
    int unsigned g;
    int unsigned b;
    int unsigned u1;
    int unsigned u2;
    logic [31:0] elapsed;
    r = 0;
    g = 0;
    b = 0;
    elapsed = now - press_ms;
    if (!btn && last_button && elapsed > 32'(debounce_limit)) begin
      fx_mode   = (fx_mode >= MODE_AURORA) ? MODE_OFF : fx_mode + 4'd1;
      press_ms  = now;
      slow_mrad = '0;
      wave_mrad = '0;
    end
    last_button = btn;
    case (fx_mode)
      MODE_PURPLE: begin
        r = 20;
        b = 80;
      end
      MODE_FLICKER: begin
        r = 180 + ra % 75;
        g = 40 + rb % (r / 3 - 40);
      end
      MODE_OCEAN: begin
        g = 100;
        b = 255;
      end
      MODE_RAINBOW: begin
        wave_mrad = phase_step(wave_mrad, 10);
        r = rainbow_level(wave_mrad);
        g = rainbow_level(wave_mrad + 2090);
        b = rainbow_level(wave_mrad + 4180);
      end
      MODE_BREATH: begin
        slow_mrad = phase_step(slow_mrad, 20);
        b = unit_level(slow_mrad) * 255 / LEVEL_FULL;
        r = b / 3;
      end
      MODE_PLASMA: begin
        slow_mrad = phase_step(slow_mrad, 50);
        u1 = unit_level(slow_mrad);
        r = u1 * 150 / LEVEL_FULL;
        b = u1 * 255 / LEVEL_FULL;
      end
      MODE_SUNSET: begin
        slow_mrad = phase_step(slow_mrad, 5);
        u1 = unit_level(slow_mrad);
        r = 255;
        g = 80 + u1 * 100 / LEVEL_FULL;
        b = u1 * 50 / LEVEL_FULL;
      end
      MODE_AURORA: begin
        wave_mrad = phase_step(wave_mrad, 15);
        u1 = unit_level(wave_mrad);
        u2 = unit_level((wave_mrad * 13) / 10 + 1000);
        r = u1 * 100 / LEVEL_FULL;
        g = u2 * 255 / LEVEL_FULL;
        b = (u1 * 200 + u2 * 55) / LEVEL_FULL;
      end
      default: begin
      end
    endcase
    if (invert_on) begin
      r = 255 - r;
      g = 255 - g;
      b = 255 - b;
    end
    d.red   = level_t'(r);
    d.green = level_t'(g);
    d.blue  = level_t'(b);
    d.mode  = fx_mode;
    return d;
  endfunction

  task automatic add_row(input logic btn, input logic [31:0] now, input logic [15:0] ra,
                         input logic [15:0] rb, input bit typed, input int r, input int g,
                         input int b, input mode_t mode);
    tick_row_t row;
    row.btn   = btn;
    row.now   = now;
    row.ra    = ra;
    row.rb    = rb;
    row.typed = typed;
    row.want  = '{level_t'(r), level_t'(g), level_t'(b), mode};
    directed_rows.push_back(row);
  endtask

  task automatic offer_tick(input logic btn, input logic [31:0] now, input logic [15:0] ra,
                            input logic [15:0] rb, input bit typed, input drive_t want);
    int     gap;
    int     r;
    drive_t pred;
    r = $urandom_range(0, 99);
    if (gap_burst > 0) begin
      gap_burst--;
      gap = 0;
    end else if (r < 5) begin
      gap_burst = 30;
      gap = 0;
    end else if (r < 55) begin
      gap = 0;
    end else if (r < 85) begin
      gap = $urandom_range(1, 3);
    end else if (r < 96) begin
      gap = $urandom_range(4, 30);
    end else begin
      gap = $urandom_range(60, 120);
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    button_level_i <= btn;
    now_ms_i       <= now;
    rand_a_i       <= ra;
    rand_b_i       <= rb;
    do @(posedge clk_i); while (in_stall_o);
    pred = led_drive(btn, now, ra, rb);
    pending_drives.push_back(typed ? want : pred);
    ticks_sent++;
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_drives.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic configure(input logic [15:0] debounce, input logic invert_bit);
    logic [15:0] invert_word;
    invert_word = {15'($urandom), invert_bit};
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_DEBOUNCE;
    cfg_wdata_i <= debounce;
    @(posedge clk_i);
    cfg_index_i <= CFG_INVERT;
    cfg_wdata_i <= invert_word;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    debounce_limit = debounce;
    invert_on      = invert_word[0];
    settings_done++;
  endtask

  // presses with long steady dwells in the sine modes so the phases wrap in all but the sunset mode
  task automatic run_random_ticks(input int count);
    logic btn_now;
    int   r;
    for (int n = 0; n < count; n++) begin
      if (btn_run == 0) begin
        btn_level = ~btn_level;
        steady    = 1'b0;
        if (!btn_level) begin
          btn_run = $urandom_range(1, 3);
        end else if (fx_mode >= MODE_RAINBOW && $urandom_range(0, 2) == 0) begin
          btn_run = $urandom_range(130, 700);
          steady  = 1'b1;
        end else begin
          btn_run = $urandom_range(1, 20);
        end
      end
      btn_run--;
      btn_now = btn_level;
      if (!steady && $urandom_range(0, 9) == 0) begin
        btn_now = 1'($urandom);
      end
      r = $urandom_range(0, 99);
      if (r < 70) begin
        sim_ms = sim_ms + 32'd20;
      end else if (r < 92) begin
        sim_ms = sim_ms + $urandom_range(0, 600);
      end else begin
        sim_ms = $urandom;
      end
      offer_tick(btn_now, sim_ms, 16'($urandom), 16'($urandom), 1'b0, '0);
    end
  endtask

  task automatic check_field(input string field, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i) begin : drive_checker
    drive_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_drives.size() == 0) begin
        $display("%0t: unexpected item, expected none, got %0d %0d %0d mode %0d", $time,
                 drive_red_o, drive_green_o, drive_blue_o, active_mode_o);
        mismatch_count++;
      end else begin
        want = pending_drives.pop_front();
        check_field("red", want.red, drive_red_o);
        check_field("green", want.green, drive_green_o);
        check_field("blue", want.blue, drive_blue_o);
        check_field("mode", want.mode, active_mode_o);
        if (active_mode_o <= MODE_AURORA) begin
          modes_seen[active_mode_o] = 1'b1;
        end
        drives_checked++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d items outstanding", $time, pending_drives.size());
      $display("testbench failed");
      $finish;
    end
  end

  initial begin : stall_driver
    int r;
    int len;
    out_stall_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_asked && !hold_served) begin
        out_stall_i <= 1'b1;
        len = HOLD_CYCLES;
        hold_served = 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 50) begin
          out_stall_i <= 1'b0;
          len = $urandom_range(1, 6);
        end else if (r < 85) begin
          out_stall_i <= 1'b1;
          len = $urandom_range(1, 3);
        end else if (r < 95) begin
          out_stall_i <= 1'b1;
          len = $urandom_range(4, 40);
        end else begin
          out_stall_i <= 1'b0;
          len = $urandom_range(50, 150);
        end
      end
      repeat (len) @(posedge clk_i);
    end
  end

  initial begin : stimulus
    longint unsigned x;
    longint unsigned term;
    longint unsigned v;
    longint          sum;

    rst_ni         <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_index_i    <= CFG_DEBOUNCE;
    cfg_wdata_i    <= '0;
    in_valid_i     <= 1'b0;
    button_level_i <= 1'b1;
    now_ms_i       <= '0;
    rand_a_i       <= '0;
    rand_b_i       <= '0;

    // quarter-wave sine table, Taylor series in Q30
    for (int i = 0; i <= SINE_ENTRIES; i++) begin
      x    = (64'(i) * QUARTER_TURN_Q30) / SINE_ENTRIES;
      term = x;
      sum  = longint'(x);
      for (int k = 1; k <= 7; k++) begin
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = term / 64'((2 * k) * (2 * k + 1));
        if (k % 2 == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      v = (64'(sum) * 64'd32767 + 64'd536870912) >> 30;
      if (v > 64'd32767) begin
        v = 64'd32767;
      end
      quarter_wave[i] = int'(v);
    end

    fx_mode        = MODE_OFF;
    last_button    = 1'b1;
    press_ms       = '0;
    slow_mrad      = '0;
    wave_mrad      = '0;
    debounce_limit = 16'd250;
    invert_on      = 1'b1;

    // debounce edge, held button, wrap of the ms clock, full mode cycle
    add_row(1'b1, 32'd0,          16'h0000, 16'h0000, 1'b1, 255, 255, 255, MODE_OFF);
    add_row(1'b0, 32'd100,        16'hFFFF, 16'hFFFF, 1'b1, 255, 255, 255, MODE_OFF);
    add_row(1'b1, 32'd200,        16'h0000, 16'h0000, 1'b1, 255, 255, 255, MODE_OFF);
    add_row(1'b0, 32'd250,        16'h0000, 16'h0000, 1'b1, 255, 255, 255, MODE_OFF);
    add_row(1'b1, 32'd251,        16'h0000, 16'h0000, 1'b1, 255, 255, 255, MODE_OFF);
    add_row(1'b0, 32'd251,        16'h0000, 16'h0000, 1'b1, 235, 255, 175, MODE_PURPLE);
    add_row(1'b0, 32'd1000,       16'hFFFF, 16'h0000, 1'b1, 235, 255, 175, MODE_PURPLE);
    add_row(1'b1, 32'd1100,       16'h0000, 16'hFFFF, 1'b1, 235, 255, 175, MODE_PURPLE);
    add_row(1'b0, 32'd1200,       16'h0000, 16'h0000, 1'b1, 75, 215, 255, MODE_FLICKER);
    add_row(1'b1, 32'd1300,       16'hFFFF, 16'hFFFF, 1'b0, 0, 0, 0, MODE_OFF);
    add_row(1'b0, 32'd1600,       16'h1234, 16'h8000, 1'b1, 255, 155, 0, MODE_OCEAN);
    add_row(1'b1, 32'd1700,       16'hFFFF, 16'hFFFF, 1'b1, 255, 155, 0, MODE_OCEAN);
    add_row(1'b0, 32'd2000,       16'h0000, 16'h0000, 1'b0, 0, 0, 0, MODE_OFF);
    add_row(1'b1, 32'd2020,       16'hFFFF, 16'h0000, 1'b0, 0, 0, 0, MODE_OFF);
    add_row(1'b0, 32'd2300,       16'h0000, 16'hFFFF, 1'b0, 0, 0, 0, MODE_OFF);
    add_row(1'b1, 32'd2320,       16'h5555, 16'hAAAA, 1'b0, 0, 0, 0, MODE_OFF);
    add_row(1'b0, 32'd2600,       16'hAAAA, 16'h5555, 1'b0, 0, 0, 0, MODE_OFF);
    add_row(1'b1, 32'd2620,       16'h0000, 16'h0000, 1'b0, 0, 0, 0, MODE_OFF);
    add_row(1'b0, 32'd2900,       16'hFFFF, 16'hFFFF, 1'b0, 0, 0, 0, MODE_OFF);
    add_row(1'b1, 32'd2920,       16'h0000, 16'h0000, 1'b0, 0, 0, 0, MODE_OFF);
    add_row(1'b0, 32'hFFFF_FF80,  16'h0000, 16'h0000, 1'b0, 0, 0, 0, MODE_OFF);
    add_row(1'b1, 32'hFFFF_FFA0,  16'hFFFF, 16'hFFFF, 1'b0, 0, 0, 0, MODE_OFF);
    add_row(1'b0, 32'h0000_0010,  16'h0000, 16'h0000, 1'b0, 0, 0, 0, MODE_OFF);
    add_row(1'b1, 32'h0000_0020,  16'h0000, 16'h0000, 1'b0, 0, 0, 0, MODE_OFF);
    add_row(1'b0, 32'h0000_0100,  16'h0000, 16'h0000, 1'b1, 255, 255, 255, MODE_OFF);
    add_row(1'b1, 32'h0000_0120,  16'hFFFF, 16'hFFFF, 1'b1, 255, 255, 255, MODE_OFF);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      offer_tick(directed_rows[i].btn, directed_rows[i].now, directed_rows[i].ra,
                 directed_rows[i].rb, directed_rows[i].typed, directed_rows[i].want);
    end
    wait_idle();
    sim_ms = 32'h0000_0200;

    configure(16'd0, 1'b0);
    run_random_ticks(260);
    wait_idle();

    configure(16'hFFFF, 1'b1);
    hold_asked = 1'b1;
    run_random_ticks(260);
    wait_idle();

    configure(16'($urandom_range(0, 400)), 1'($urandom));
    run_random_ticks(260);
    wait_idle();

    configure(16'd250, 1'b0);
    run_random_ticks(260);
    wait_idle();

    $display("%0d ticks sent, %0d results checked, %0d register settings", ticks_sent,
             drives_checked, settings_done);
    $display("modes reached (bit per mode, 8 down to 0): %b", modes_seen);
    if (mismatch_count == 0 && pending_drives.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
